/* rtl/core/lst_pkg.sv */
package lst_pkg;

	localparam int SLOT_W = 7;
	localparam int ADDR_W = 14;
	localparam int ST_W   = 7;
	localparam int SSC_W  = 3;

	localparam logic [2:0] OP_FIND     = 3'd0;
	localparam logic [2:0] OP_FIND_ADD = 3'd1;
	localparam logic [2:0] OP_REQUEST  = 3'd2;
	localparam logic [2:0] OP_DISPATCH = 3'd3;
	localparam logic [2:0] OP_MOVE     = 3'd4;
	localparam logic [2:0] OP_WRITE    = 3'd5;
	localparam logic [2:0] OP_READ     = 3'd6;

	localparam logic [2:0] RK_NONE     = 3'd0;
	localparam logic [2:0] RK_DATA     = 3'd1;
	localparam logic [2:0] RK_NO_SLOT  = 3'd2;
	localparam logic [2:0] RK_ILLEGAL  = 3'd3;
	localparam logic [2:0] RK_WRITTEN  = 3'd4;

	localparam logic [SLOT_W-1:0] REPORT_LIMIT = 7'd120;
	localparam logic [ST_W-1:0]   ST_IN_USE    = 7'h30;
	localparam logic [ST_W-1:0]   ST_ALLOC     = 7'h10;
	localparam logic [1:0]        USE_COMMON   = 2'b11;
	localparam logic [1:0]        USE_FREE     = 2'b00;
	localparam logic [SSC_W-1:0]  SSC_RESET    = 3'd7;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [ADDR_W-1:0] loco_address;
		logic [SLOT_W-1:0] slot_src;
		logic [SLOT_W-1:0] slot_dst;
		logic [ST_W-1:0]   status_in;
	} lst_in_t;

	typedef struct packed {
		logic [2:0]        reply_kind;
		logic [SLOT_W-1:0] slot_number;
		logic [ST_W-1:0]   slot_status;
		logic [ADDR_W-1:0] slot_address;
		logic              slot_data_valid;
	} lst_out_t;

	// scan word walking the cell chain
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [SLOT_W-1:0] hit_idx;
		logic [ST_W-1:0]   hit_status;
		logic [ADDR_W-1:0] hit_addr;
		logic              free_ok;
		logic [SLOT_W-1:0] free_idx;
		logic              tgt_ok;
		logic [ST_W-1:0]   tgt_status;
		logic [ADDR_W-1:0] tgt_addr;
	} lst_tok_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		logic [ADDR_W-1:0] addr;
		logic [ST_W-1:0]   status;
	} lst_wr_t;

	function automatic lst_out_t lst_report(input logic [SLOT_W-1:0] slot,
			input logic [ST_W-1:0] st, input logic [ADDR_W-1:0] ad);
		lst_out_t o;
		o = '0;
		o.slot_number = slot;
		if (slot < REPORT_LIMIT) begin
			o.reply_kind      = RK_DATA;
			o.slot_data_valid = 1'b1;
			o.slot_status     = st;
			o.slot_address    = ad;
		end
		return o;
	endfunction

endpackage

/* rtl/core/lst_cell.sv */
module lst_cell import lst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] slot_idx,
	input  logic [ADDR_W-1:0] query,
	input  logic [SLOT_W-1:0] target,
	input  lst_wr_t           wr,
	input  lst_tok_t          tok_in,
	output lst_tok_t          tok_out
);

	logic [ADDR_W-1:0] addr_q;
	logic [ST_W-1:0]   status_q;
	lst_tok_t          tok_q;
	lst_tok_t          tok_nxt;

	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit && addr_q == query) begin
			tok_nxt.hit        = 1'b1;
			tok_nxt.hit_idx    = slot_idx;
			tok_nxt.hit_status = status_q;
			tok_nxt.hit_addr   = addr_q;
		end
		if (!tok_in.free_ok && status_q[5:4] == USE_FREE) begin
			tok_nxt.free_ok  = 1'b1;
			tok_nxt.free_idx = slot_idx;
		end
		if (slot_idx == target) begin
			tok_nxt.tgt_ok     = 1'b1;
			tok_nxt.tgt_status = status_q;
			tok_nxt.tgt_addr   = addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			status_q <= '0;
			tok_q    <= '0;
		end else begin
			if (wr.en && wr.idx == slot_idx) begin
				addr_q   <= wr.addr;
				status_q <= wr.status;
			end
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/core/lst_ctrl.sv */
module lst_ctrl import lst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SSC_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  lst_in_t           in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output lst_out_t          out_word,
	output lst_tok_t          start,
	output logic [ADDR_W-1:0] query,
	output logic [SLOT_W-1:0] target,
	input  lst_tok_t          tok_end,
	output lst_wr_t           wr
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		FIN
	} state_t;

	state_t            state_q;
	logic [SSC_W-1:0]  ssc_q;
	logic [SLOT_W-1:0] disp_q;
	lst_in_t           item_q;
	logic [SLOT_W-1:0] target_q;
	logic              start_q;
	lst_tok_t          end_q;
	logic              out_valid_q;
	lst_out_t          out_q;
	lst_wr_t           wr_q;

	logic              accept;
	logic              out_free;
	logic [SLOT_W-1:0] tgt_sel;

	lst_out_t          fin_out;
	lst_wr_t           fin_wr;
	logic [SLOT_W-1:0] fin_disp;

	logic              adr_nz;
	logic              found;
	logic              alloc;
	logic [SLOT_W-1:0] lk_slot;
	logic [ST_W-1:0]   lk_st;
	logic [ADDR_W-1:0] lk_ad;
	logic [ST_W-1:0]   mark_st;
	logic [ADDR_W-1:0] tgt_ad;

	assign in_stall = (state_q != IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign tgt_sel = ((in_word.opcode == OP_MOVE && in_word.slot_src == '0) ||
		(in_word.opcode == OP_REQUEST && in_word.loco_address == '0)) ?
		disp_q : in_word.slot_src;

	always_comb begin
		adr_nz  = (item_q.loco_address != '0);
		found   = adr_nz && end_q.hit;
		alloc   = adr_nz && !end_q.hit && end_q.free_ok;
		lk_slot = '0;
		lk_st   = '0;
		lk_ad   = '0;
		if (found) begin
			lk_slot = end_q.hit_idx;
			lk_st   = end_q.hit_status;
			lk_ad   = end_q.hit_addr;
		end else if (alloc) begin
			lk_slot = end_q.free_idx;
			lk_st   = ST_ALLOC | {{(ST_W-SSC_W){1'b0}}, ssc_q};
			lk_ad   = item_q.loco_address;
		end
		mark_st = end_q.tgt_ok ? (end_q.tgt_status | ST_IN_USE) : '0;
		tgt_ad  = end_q.tgt_ok ? end_q.tgt_addr : '0;

		fin_out  = '0;
		fin_disp = disp_q;
		fin_wr   = '0;
		fin_wr.idx    = lk_slot;
		fin_wr.addr   = lk_ad;
		fin_wr.status = lk_st;

		unique case (item_q.opcode)
			OP_FIND: begin
				fin_out.slot_number = found ? end_q.hit_idx : '0;
			end
			OP_FIND_ADD: begin
				fin_wr.en = alloc;
				if (alloc) begin
					fin_out = lst_report(lk_slot, lk_st, lk_ad);
				end else begin
					fin_out.slot_number = lk_slot;
				end
			end
			OP_REQUEST: begin
				fin_wr.en = alloc;
				if (disp_q != '0 && !adr_nz) begin
					fin_out = lst_report(disp_q, end_q.tgt_status, end_q.tgt_addr);
					if (!end_q.tgt_ok) begin
						fin_out.slot_status  = '0;
						fin_out.slot_address = '0;
					end
				end else if (lk_slot == '0) begin
					fin_out.reply_kind = RK_NO_SLOT;
				end else begin
					fin_out = lst_report(lk_slot, lk_st, lk_ad);
				end
			end
			OP_DISPATCH: begin
				fin_wr.en = alloc;
				if (lk_st[5:4] == USE_COMMON) begin
					fin_disp = '0;
				end else begin
					fin_disp = lk_slot;
					if (alloc) begin
						fin_out = lst_report(lk_slot, lk_st, lk_ad);
					end else begin
						fin_out.slot_number = lk_slot;
					end
				end
			end
			OP_MOVE: begin
				fin_wr.idx    = target_q;
				fin_wr.addr   = end_q.tgt_addr;
				fin_wr.status = mark_st;
				if (item_q.slot_src == '0) begin
					if (disp_q != '0) begin
						fin_wr.en = end_q.tgt_ok;
						fin_out   = lst_report(disp_q, mark_st, tgt_ad);
						fin_disp  = '0;
					end else begin
						fin_out.reply_kind = RK_ILLEGAL;
					end
				end else if (item_q.slot_src == item_q.slot_dst) begin
					fin_wr.en = end_q.tgt_ok;
					fin_out   = lst_report(item_q.slot_src, mark_st, tgt_ad);
				end else if (item_q.slot_dst == '0) begin
					fin_disp = item_q.slot_src;
					fin_out  = lst_report(item_q.slot_src,
						end_q.tgt_ok ? end_q.tgt_status : '0, tgt_ad);
				end else begin
					fin_out.reply_kind = RK_ILLEGAL;
				end
			end
			OP_WRITE: begin
				fin_wr.en     = end_q.tgt_ok;
				fin_wr.idx    = item_q.slot_src;
				fin_wr.addr   = item_q.loco_address;
				fin_wr.status = item_q.status_in;
				fin_out = lst_report(item_q.slot_src,
					end_q.tgt_ok ? item_q.status_in : '0,
					end_q.tgt_ok ? item_q.loco_address : '0);
				fin_out.reply_kind = RK_WRITTEN;
			end
			OP_READ: begin
				fin_out = lst_report(item_q.slot_src,
					end_q.tgt_ok ? end_q.tgt_status : '0, tgt_ad);
			end
			default: begin
				fin_out = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			ssc_q       <= SSC_RESET;
			disp_q      <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			wr_q        <= '0;
		end else begin
			if (cfg_we) begin
				ssc_q <= cfg_wdata;
			end
			start_q <= 1'b0;
			wr_q.en <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						start_q <= 1'b1;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (tok_end.valid) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						disp_q      <= fin_disp;
						wr_q        <= fin_wr;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= in_word;
			target_q <= tgt_sel;
		end
		if (state_q == SCAN && tok_end.valid) begin
			end_q <= tok_end;
		end
		if (state_q == FIN && out_free) begin
			out_q <= fin_out;
		end
	end

	always_comb begin
		start       = '0;
		start.valid = start_q;
	end

	assign query     = item_q.loco_address;
	assign target    = target_q;
	assign wr        = wr_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

/* rtl/core/loco_slot_table.sv */
// Locomotive slot table. Slots 1 to NUM_SLOTS-1 each live in one cell of a
// chain; a request sends one scan word down the chain, which picks up the
// matching slot, the first free slot and the addressed slot on its way, and
// the controller then answers and writes back at most one slot. The scan
// walks one cell per cycle; the controller then registers the scan result
// and forms the answer in the output register. The block takes no new word
// until the result of the last one is in the output register. The speed
// step code register may be written at any time the block is idle and
// resets to 128 steps.
module loco_slot_table import lst_pkg::*; #(
	parameter int NUM_SLOTS = 120
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [SSC_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  lst_in_t          in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output lst_out_t         out_word
);

	lst_tok_t          tok_w [NUM_SLOTS];
	logic [ADDR_W-1:0] query;
	logic [SLOT_W-1:0] target;
	lst_wr_t           wr;

	lst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.start     (tok_w[0]),
		.query     (query),
		.target    (target),
		.tok_end   (tok_w[NUM_SLOTS-1]),
		.wr        (wr)
	);

	for (genvar i = 1; i < NUM_SLOTS; i++) begin : g_cell
		lst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_idx (SLOT_W'(i)),
			.query    (query),
			.target   (target),
			.wr       (wr),
			.tok_in   (tok_w[i-1]),
			.tok_out  (tok_w[i])
		);
	end

endmodule
